/* rtl/core/bmsm_pkg.sv */
// ----------------------------------------------------------------------------
// bmsm_pkg: shared types, sizes and helpers for the 3x3 majority smoother
// Frame limits, register codes, the control bundle from the sequencer to the
// window datapath, and the keep/clear/set rule.
// ----------------------------------------------------------------------------
package bmsm_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 11;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 11;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int TDATA_W      = 8;
  localparam int CNT_W        = 4;
  localparam int NB_NUM       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 9'd200;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 11'd100;

  typedef struct packed {
    logic             take;     // transfer that advances the window
    logic             decide;   // a pixel is decided on this transfer
    logic             bit_in;   // incoming bit, zero in the flush tail
    logic             raw_we;
    logic [COL_W-1:0] raw_wa;
    logic [COL_W-1:0] rd_col;   // column of the next pixel to decide
    logic [COL_W-1:0] wr_col;   // column of the pixel decided now
    logic             up;
    logic             dn;
    logic             lf;
    logic             rt;
    logic             last;
  } bmsm_ctl_t;

  function automatic logic smooth_bit(input logic cur, input logic [CNT_W-1:0] n,
                                      input logic [CNT_W-1:0] v);
    logic [CNT_W+1:0] n5;
    logic [CNT_W+1:0] v2;
    logic [CNT_W+1:0] v3;
    logic             res;
    n5 = ({2'b00, n} << 2) + {2'b00, n};
    v2 = {2'b00, v} << 1;
    v3 = v2 + {2'b00, v};
    if (v == '0) begin
      res = cur;
    end else if (n5 <= v2) begin
      res = 1'b0;
    end else if (n5 >= v3) begin
      res = 1'b1;
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage

/* rtl/core/bmsm_lbuf.sv */
// ----------------------------------------------------------------------------
// bmsm_lbuf: one-bit line buffer RAM
// One write port and two read ports, read data registered, read-first.
// ----------------------------------------------------------------------------
module bmsm_lbuf #(
  parameter int Depth = 256,
  localparam int AW = $clog2(Depth)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic          wd,
  input  logic          re,
  input  logic [AW-1:0] ra_a,
  input  logic [AW-1:0] ra_b,
  output logic          rd_a,
  output logic          rd_b
);

  logic mem [Depth];
  logic rd_a_r;
  logic rd_b_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

/* rtl/core/bmsm_ctrl.sv */
// ----------------------------------------------------------------------------
// bmsm_ctrl: frame sequencer
// Holds the frame registers and the input and output raster counters, and
// tells the window datapath what each transfer does.
// ----------------------------------------------------------------------------
module bmsm_ctrl
  import bmsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_fire,
  input  logic                  in_cmd,
  input  logic                  in_pixel,
  output bmsm_ctl_t             ctl
);

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [ROW_W-1:0]        in_row_r, in_row_nxt;
  logic [COL_W-1:0]        in_col_r, in_col_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic [COL_W-1:0]        out_col_r, out_col_nxt;
  logic [COL_W-1:0]        w_last;
  logic [ROW_W-1:0]        h_last;
  logic                    in_frame;
  logic                    ready;
  logic                    take;
  logic                    decide;
  logic                    dn;
  logic                    rt;
  logic                    last;

  always_comb begin
    if (width_r == '0) begin
      w_last = '0;
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      h_last = '0;
    end else begin
      h_last = ROW_W'(height_r - 1'b1);
    end
  end

  assign in_frame = (in_row_r <= h_last);
  assign ready    = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign take     = in_fire && !(in_frame && in_cmd);
  assign decide   = take && ready;
  assign dn       = (out_row_r != h_last);
  assign rt       = (out_col_r != w_last);
  assign last     = !dn && !rt;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (take) begin
      if (in_frame) begin
        if (in_col_r == w_last) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + 1'b1;
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
      end else if (in_col_r == '0) begin
        in_col_nxt = COL_W'(1);
      end
    end
    if (decide) begin
      if (last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else if (rt) begin
        out_col_nxt = out_col_r + 1'b1;
      end else begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_r <= cfg_wdata[CFG_WIDTH_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        end
        default: begin
          width_r <= width_r;
        end
      endcase
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  always_comb begin
    ctl.take   = take;
    ctl.decide = decide;
    ctl.bit_in = in_frame & in_pixel;
    ctl.raw_we = take && in_frame;
    ctl.raw_wa = in_col_r;
    ctl.rd_col = out_col_nxt;
    ctl.wr_col = out_col_r;
    ctl.up     = (out_row_r != '0);
    ctl.dn     = dn;
    ctl.lf     = (out_col_r != '0);
    ctl.rt     = rt;
    ctl.last   = last;
  end

endmodule

/* rtl/core/bmsm_window.sv */
// ----------------------------------------------------------------------------
// bmsm_window: 3x3 window and decision
// Raw and smoothed line buffers, the small neighbor registers, and the
// count-and-compare rule for the pixel under decision.
// ----------------------------------------------------------------------------
module bmsm_window
  import bmsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bmsm_ctl_t ctl,
  output logic      result
);

  logic [COL_W-1:0]  rd_col_p1;
  logic              raw_c;
  logic              raw_r;
  logic              sm_a;
  logic              sm_b;
  logic              top_c;
  logic              top_r;
  logic              s1_r;
  logic              s2_r;
  logic              topl_r;
  logic              left_r;
  logic              fwd_a_r;
  logic              fwd_b_r;
  logic [NB_NUM-1:0] nb;
  logic [NB_NUM-1:0] msk;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  v;

  assign rd_col_p1 = ctl.rd_col + 1'b1;

  bmsm_lbuf #(.Depth(MAX_WIDTH)) u_raw_buf (
    .clk  (clk),
    .we   (ctl.raw_we),
    .wa   (ctl.raw_wa),
    .wd   (ctl.bit_in),
    .re   (ctl.take),
    .ra_a (ctl.rd_col),
    .ra_b (rd_col_p1),
    .rd_a (raw_c),
    .rd_b (raw_r)
  );

  bmsm_lbuf #(.Depth(MAX_WIDTH)) u_sm_buf (
    .clk  (clk),
    .we   (ctl.decide),
    .wa   (ctl.wr_col),
    .wd   (result),
    .re   (ctl.take),
    .ra_a (ctl.rd_col),
    .ra_b (rd_col_p1),
    .rd_a (sm_a),
    .rd_b (sm_b)
  );

  // bypass a smoothed bit written on the same transfer that read its column
  assign top_c = fwd_a_r ? left_r : sm_a;
  assign top_r = fwd_b_r ? left_r : sm_b;

  always_comb begin
    nb  = {ctl.bit_in, s1_r, s2_r, raw_r, left_r, top_r, top_c, topl_r};
    msk = {ctl.dn & ctl.rt, ctl.dn, ctl.dn & ctl.lf, ctl.rt, ctl.lf,
           ctl.up & ctl.rt, ctl.up, ctl.up & ctl.lf};
    n   = '0;
    v   = '0;
    for (int i = 0; i < NB_NUM; i++) begin
      n = n + CNT_W'(nb[i] & msk[i]);
      v = v + CNT_W'(msk[i]);
    end
  end

  assign result = smooth_bit(raw_c, n, v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else if (ctl.take) begin
      fwd_a_r <= ctl.decide && (ctl.wr_col == ctl.rd_col);
      fwd_b_r <= ctl.decide && (ctl.wr_col == rd_col_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      s1_r   <= ctl.bit_in;
      s2_r   <= s1_r;
      topl_r <= top_c;
    end
    if (ctl.decide) begin
      left_r <= result;
    end
  end

endmodule

/* rtl/core/binary_majority_smoothing_3x3_core.sv */
// ----------------------------------------------------------------------------
// binary_majority_smoothing_3x3_core: in-place 3x3 majority smoother
// Takes one pixel bit per transfer in raster order and accepts a new
// transfer every cycle while the output holds no stalled result. The result
// for a pixel leaves with the transfer that brings the pixel frame_width + 1
// positions later, registered in the cycle after that transfer; after the last pixel send
// frame_width + 1 flush transfers. The rate is set by the two 256 x 1 line
// buffers (one raw, one smoothed), each read at two columns and written at
// one per transfer. The line buffers need no clearing pass after reset.
// ----------------------------------------------------------------------------
module binary_majority_smoothing_3x3_core
  import bmsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [0] pixel_on, [7:1] zero
  input  logic                  in_tuser,   // [0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [0] smoothed_on, [7:1] zero
  output logic                  out_tlast
);

  bmsm_ctl_t ctl;
  logic      in_fire;
  logic      result;
  logic      out_valid_r;
  logic      out_bit_r;
  logic      out_last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  bmsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_cmd    (in_tuser),
    .in_pixel  (in_tdata[0]),
    .ctl       (ctl)
  );

  bmsm_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.decide) begin
      out_bit_r  <= result;
      out_last_r <= ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-1){1'b0}}, out_bit_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/bmsm_checker.sv */
// ----------------------------------------------------------------------------
// bmsm_checker: port-level checks for the majority smoother
// Watches the top-level ports only; attached to the core by bind.
// ----------------------------------------------------------------------------
module bmsm_checker
  import bmsm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic                  out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:1] == '0)
    else $error("result padding bits not zero");

  // a fresh result only follows an input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!$past(out_tvalid) || $past(out_tready)) |->
      $past(in_tvalid && in_tready))
    else $error("result without input transfer");

  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind binary_majority_smoothing_3x3_core bmsm_checker u_bmsm_checker (.*);
